// File: rtl/core/ptst_pkg.sv
package ptst_pkg;

  // table geometry
  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned IDX_W = 4;

  // default wait after reset
  localparam logic [31:0] DEFAULT_WAIT_RST = 32'd1000;

  // input modes
  localparam logic [1:0] MODE_SET = 2'd0;
  localparam logic [1:0] MODE_CHANGE = 2'd1;
  localparam logic [1:0] MODE_SCAN = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SET = 2'd0;
  localparam logic [1:0] KIND_CHANGE = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  // one slot record as kept in the slot memory
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] remaining;
    logic [31:0] target;
    logic [63:0] start;
  } slot_rec_t;

  // one fired slot as kept in the result buffer
  typedef struct packed {
    slot_idx_t   idx;
    logic [31:0] id;
    logic        freed;
  } fire_ent_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic issue;
    logic load_single;
    logic buf_rd;
    logic buf_load;
  } ptst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_end;
    logic scan_hits;
    logic drain_last;
    logic out_free;
  } ptst_sts_t;

  // slot number as it appears on the result port
  function automatic logic [IDX_W-1:0] to_idx4(input slot_idx_t v);
    logic [SLOT_W+IDX_W-1:0] t;
    t = {{IDX_W{1'b0}}, v};
    return t[IDX_W-1:0];
  endfunction

endpackage

// File: rtl/core/ptst_ram.sv
module ptst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ptst_ctrl.sv
module ptst_ctrl
  import ptst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ptst_sts_t sts_i,
  output ptst_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SWEEP    = 6'b000010,
    ST_TAIL     = 6'b000100,
    ST_REPLY    = 6'b001000,
    ST_DRAIN_RD = 6'b010000,
    ST_DRAIN_LD = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.issue = 1'b1;
        if (sts_i.sweep_end) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_REPLY;
      end
      ST_REPLY: begin
        if (sts_i.scan_hits) begin
          state_d = ST_DRAIN_RD;
        end else if (sts_i.out_free) begin
          cmd_o.load_single = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DRAIN_RD: begin
        cmd_o.buf_rd = 1'b1;
        state_d = ST_DRAIN_LD;
      end
      ST_DRAIN_LD: begin
        if (sts_i.out_free) begin
          cmd_o.buf_load = 1'b1;
          state_d = sts_i.drain_last ? ST_IDLE : ST_DRAIN_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef NO_ASSERTIONS
  // draining the result buffer only happens after a scan that fired
  a_drain_needs_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN_RD) |-> sts_i.scan_hits)
    else $error("result buffer drained without fired slots");
`endif

endmodule

// File: rtl/core/ptst_dp.sv
module ptst_dp
  import ptst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptst_cmd_t        cmd_i,
  output ptst_sts_t        sts_o,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_data_i,
  input  logic [1:0]       mode_i,
  input  logic [31:0]      period_ms_i,
  input  logic [31:0]      repeat_count_i,
  input  logic [31:0]      target_id_i,
  input  logic [63:0]      now_ms_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic             ok_o,
  output logic [IDX_W-1:0] slot_index_o,
  output logic [31:0]      fired_id_o,
  output logic             slot_freed_o,
  output logic [31:0]      next_wait_ms_o,
  output logic             last_o
);

  // configuration and table flags
  logic [31:0]            dflt_wait_q;
  logic [TIMER_SLOTS-1:0] used_q, used_d;

  // latched item
  logic [1:0]  mode_q;
  logic [31:0] period_q, reps_q, target_q;
  logic [63:0] now_q;

  // sweep bookkeeping
  slot_idx_t   iss_q, pipe_addr_q, set_idx_q, hit_idx_q, rptr_q;
  logic        pipe_vld_q, set_ok_q, found_q;
  logic [CNT_W-1:0] fire_cnt_q;
  logic [31:0] min_q;

  // output register
  logic             out_valid_q;
  logic [1:0]       kind_q;
  logic             ok_q, freed_q, last_q;
  logic [IDX_W-1:0] idx_q;
  logic [31:0]      id_q, wait_q;

  // free slot search
  logic      free_ok;
  slot_idx_t free_idx;

  // slot stage
  logic [$bits(slot_rec_t)-1:0] slot_rdata;
  slot_rec_t rec, wrec;
  logic      pu, is_set, is_chg, is_scan;
  logic      set_hit, chg_hit, fire, freed, slot_we;
  logic      eff_used;
  logic [31:0] eff_period;
  logic [63:0] elapsed;

  // result buffer
  logic [$bits(fire_ent_t)-1:0] buf_rdata;
  fire_ent_t ent_w, ent_r;

  // lowest free slot from the used flags
  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_ok = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // default wait register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_wait_q <= DEFAULT_WAIT_RST;
    end else if (cfg_we_i) begin
      dflt_wait_q <= cfg_data_i;
    end
  end

  // slot memory, one record per slot
  ptst_ram #(
    .WIDTH($bits(slot_rec_t)),
    .DEPTH(TIMER_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(pipe_addr_q),
    .wdata_i(wrec),
    .re_i   (cmd_i.issue),
    .raddr_i(iss_q),
    .rdata_o(slot_rdata)
  );

  // per slot update for the slot whose record just came back
  always_comb begin
    rec = slot_rec_t'(slot_rdata);
    is_set = (mode_q == MODE_SET);
    is_chg = (mode_q == MODE_CHANGE);
    is_scan = (mode_q == MODE_SCAN);
    pu = used_q[pipe_addr_q];
    elapsed = now_q - rec.start;
    set_hit = is_set && set_ok_q && (pipe_addr_q == set_idx_q);
    chg_hit = is_chg && !found_q && pu && (rec.target == target_q);
    fire = is_scan && pu && (elapsed >= {32'd0, rec.period});
    freed = fire && (rec.remaining == 32'd1);
    wrec = rec;
    if (set_hit) begin
      wrec.period = period_q;
      wrec.remaining = reps_q;
      wrec.target = target_q;
      wrec.start = now_q;
    end else if (chg_hit) begin
      wrec.period = period_q;
    end else if (fire) begin
      wrec.start = now_q;
      if (rec.remaining != 32'd0) begin
        wrec.remaining = rec.remaining - 32'd1;
      end
    end
    slot_we = pipe_vld_q && (set_hit || chg_hit || fire);
    eff_used = set_hit ? 1'b1 : (fire ? !freed : pu);
    eff_period = (set_hit || chg_hit) ? period_q : rec.period;
    used_d = used_q;
    if (pipe_vld_q && set_hit) begin
      used_d[pipe_addr_q] = 1'b1;
    end
    if (pipe_vld_q && freed) begin
      used_d[pipe_addr_q] = 1'b0;
    end
  end

  // fired slots wait here until the wait period is known
  assign ent_w = '{idx: pipe_addr_q, id: rec.target, freed: freed};

  ptst_ram #(
    .WIDTH($bits(fire_ent_t)),
    .DEPTH(TIMER_SLOTS)
  ) u_fire_buf (
    .clk_i  (clk_i),
    .we_i   (pipe_vld_q && fire),
    .waddr_i(fire_cnt_q[SLOT_W-1:0]),
    .wdata_i(ent_w),
    .re_i   (cmd_i.buf_rd),
    .raddr_i(rptr_q),
    .rdata_o(buf_rdata)
  );

  assign ent_r = fire_ent_t'(buf_rdata);

  // control state of the sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      pipe_vld_q <= 1'b0;
      iss_q <= '0;
      fire_cnt_q <= '0;
      found_q <= 1'b0;
      rptr_q <= '0;
    end else begin
      used_q <= used_d;
      pipe_vld_q <= cmd_i.issue;
      if (cmd_i.accept) begin
        iss_q <= '0;
        fire_cnt_q <= '0;
        found_q <= 1'b0;
        rptr_q <= '0;
      end else begin
        if (cmd_i.issue) begin
          iss_q <= iss_q + SLOT_W'(1);
        end
        if (pipe_vld_q && fire) begin
          fire_cnt_q <= fire_cnt_q + CNT_W'(1);
        end
        if (pipe_vld_q && chg_hit) begin
          found_q <= 1'b1;
        end
        if (cmd_i.buf_load) begin
          rptr_q <= rptr_q + SLOT_W'(1);
        end
      end
    end
  end

  // item payload, running minimum and slot numbers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_i;
      period_q <= period_ms_i;
      reps_q <= repeat_count_i;
      target_q <= target_id_i;
      now_q <= now_ms_i;
      set_ok_q <= free_ok;
      set_idx_q <= free_idx;
      min_q <= dflt_wait_q;
    end else if (pipe_vld_q) begin
      if (eff_used && (eff_period < min_q)) begin
        min_q <= eff_period;
      end
      if (chg_hit) begin
        hit_idx_q <= pipe_addr_q;
      end
    end
    if (cmd_i.issue) begin
      pipe_addr_q <= iss_q;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_single || cmd_i.buf_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_load) begin
      kind_q <= KIND_FIRED;
      ok_q <= 1'b1;
      idx_q <= to_idx4(ent_r.idx);
      id_q <= ent_r.id;
      freed_q <= ent_r.freed;
      wait_q <= min_q;
      last_q <= sts_o.drain_last;
    end else if (cmd_i.load_single) begin
      id_q <= '0;
      freed_q <= 1'b0;
      wait_q <= min_q;
      last_q <= 1'b1;
      case (mode_q)
        MODE_SET: begin
          kind_q <= KIND_SET;
          ok_q <= set_ok_q;
          idx_q <= set_ok_q ? to_idx4(set_idx_q) : '0;
        end
        MODE_CHANGE: begin
          kind_q <= KIND_CHANGE;
          ok_q <= found_q;
          idx_q <= found_q ? to_idx4(hit_idx_q) : '0;
        end
        default: begin
          kind_q <= KIND_NONE;
          ok_q <= 1'b0;
          idx_q <= '0;
        end
      endcase
    end
  end

  // status to the controller
  assign sts_o.sweep_end = (iss_q == SLOT_W'(TIMER_SLOTS - 1));
  assign sts_o.scan_hits = (mode_q == MODE_SCAN) && (fire_cnt_q != '0);
  assign sts_o.drain_last = ((CNT_W'(rptr_q) + CNT_W'(1)) == fire_cnt_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign ok_o = ok_q;
  assign slot_index_o = idx_q;
  assign fired_id_o = id_q;
  assign slot_freed_o = freed_q;
  assign next_wait_ms_o = wait_q;
  assign last_o = last_q;

`ifndef NO_ASSERTIONS
  // never more fired slots than the table holds
  a_fire_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_cnt_q <= CNT_W'(TIMER_SLOTS))
    else $error("fired slot count beyond table size");

  // a result is only loaded when the output register can take it
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_single || cmd_i.buf_load) |-> sts_o.out_free)
    else $error("result loaded over a pending result");

  // no slot update is in flight when the next transaction starts
  a_accept_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !pipe_vld_q)
    else $error("transaction accepted during a sweep");

  // a successful set reply leaves its slot marked used
  a_set_marks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_single && (mode_q == MODE_SET) && set_ok_q) |-> used_q[set_idx_q])
    else $error("set reply for a slot that is not used");
`endif

endmodule

// File: rtl/core/periodic_timer_slot_table_unit.sv
// Timer slot table: keeps 16 timer slots (period, remaining repeats, target id,
// start time) in a slot memory and serves one transaction at a time. Set takes
// the lowest free slot, change rewrites the period of the lowest used slot with
// a matching id, and scan fires every used slot whose elapsed time reached its
// period, restarting it and freeing it after its last repeat. Every transaction
// walks the whole slot memory one slot per cycle. The single result of a set,
// change, empty scan or unused mode is loaded into the output register once
// the sweep is through and the output register is free; only then can a new
// transaction be taken. A scan that fires presents its fired results one
// after another, as each is read back from a small result buffer and then
// loaded into the output register; output stalls hold them back. All results
// of a transaction carry the same next_wait_ms, the smallest used period
// capped by the default wait. A new transaction is taken while the last result
// still waits in the output register. The default wait register is written
// through its own port and must only be written while no transaction is in
// progress.
module periodic_timer_slot_table_unit
  import ptst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [31:0]      cfg_default_wait_ms_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       mode_i,
  input  logic [31:0]      period_ms_i,
  input  logic [31:0]      repeat_count_i,
  input  logic [31:0]      target_id_i,
  input  logic [63:0]      now_ms_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic             ok_o,
  output logic [IDX_W-1:0] slot_index_o,
  output logic [31:0]      fired_id_o,
  output logic             slot_freed_o,
  output logic [31:0]      next_wait_ms_o,
  output logic             last_o
);

  ptst_cmd_t cmd;
  ptst_sts_t sts;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencing
  ptst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // slot table, result buffer and output register
  ptst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_default_wait_ms_i),
    .mode_i        (mode_i),
    .period_ms_i   (period_ms_i),
    .repeat_count_i(repeat_count_i),
    .target_id_i   (target_id_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .ok_o          (ok_o),
    .slot_index_o  (slot_index_o),
    .fired_id_o    (fired_id_o),
    .slot_freed_o  (slot_freed_o),
    .next_wait_ms_o(next_wait_ms_o),
    .last_o        (last_o)
  );

endmodule
